// ===== src/i2cra_pkg.sv =====
// Package for the I2C register access master.
// Holds the transaction payload structs, the sequencer phase encoding and slot codes.
// No dependencies.
`default_nettype none

package i2cra_pkg;

	localparam int unsigned AddrWidth = 7;
	localparam int unsigned ByteWidth = 8;
	localparam int unsigned CountWidth = 4;
	localparam logic [AddrWidth-1:0] DeviceAddressReset = AddrWidth'(104);
	localparam logic [CountWidth-1:0] BitsPerByte = CountWidth'(8);

	localparam logic OpWrite = 1'b0;
	localparam logic OpRead = 1'b1;

	typedef struct packed {
		logic                 start_request;
		logic                 operation;
		logic [ByteWidth-1:0] register_address;
		logic [ByteWidth-1:0] write_data;
		logic                 sda_sample;
	} req_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_level;
		logic                 busy_res;
		logic                 done_res;
		logic [ByteWidth-1:0] read_data;
		logic                 nack_seen;
	} rsp_t;

	typedef enum logic [14:0] {
		PH_IDLE       = 15'b000000000000001,
		PH_START_A    = 15'b000000000000010,
		PH_START_B    = 15'b000000000000100,
		PH_BIT_LOW    = 15'b000000000001000,
		PH_BIT_HIGH   = 15'b000000000010000,
		PH_ACK_LOW    = 15'b000000000100000,
		PH_ACK_HIGH   = 15'b000000001000000,
		PH_RESTART    = 15'b000000010000000,
		PH_RECV_LOW   = 15'b000000100000000,
		PH_RECV_HIGH  = 15'b000001000000000,
		PH_MNACK_LOW  = 15'b000010000000000,
		PH_MNACK_HIGH = 15'b000100000000000,
		PH_STOP_A     = 15'b001000000000000,
		PH_STOP_B     = 15'b010000000000000,
		PH_STOP_C     = 15'b100000000000000
	} phase_t;

	typedef enum logic [1:0] {
		SLOT_DEV_W = 2'd0,
		SLOT_REG   = 2'd1,
		SLOT_DATA  = 2'd2,
		SLOT_DEV_R = 2'd3
	} slot_t;

endpackage

`default_nettype wire

// ===== src/i2cra_seq.sv =====
// Bus sequencer of the I2C register access master: phase, slot, shifter and latches.
// Advances one half-bit tick per step and presents the result of the new state.
// Depends on i2cra_pkg.
`default_nettype none

module i2cra_seq
	import i2cra_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire req_t                 item,
	input  wire logic [AddrWidth-1:0] device_address,
	output rsp_t                      result
);

	phase_t                phase_q, phase_d;
	slot_t                 slot_q, slot_d;
	logic [CountWidth-1:0] bit_count_q, bit_count_d;
	logic [ByteWidth-1:0]  shift_byte_q, shift_byte_d;
	logic                  latched_operation_q, latched_operation_d;
	logic [ByteWidth-1:0]  latched_register_q, latched_register_d;
	logic [ByteWidth-1:0]  latched_data_q, latched_data_d;
	logic [ByteWidth-1:0]  received_byte_q, received_byte_d;
	logic                  nack_flag_q, nack_flag_d;
	logic [CountWidth-1:0] count_inc;
	logic [ByteWidth-1:0]  recv_shift;
	logic [ByteWidth-1:0]  addr_byte;

	assign count_inc  = bit_count_q + CountWidth'(1);
	assign recv_shift = {shift_byte_q[ByteWidth-2:0], item.sda_sample};
	assign addr_byte  = {device_address, (slot_q == SLOT_DEV_R)};

	always_comb begin
		phase_d             = phase_q;
		slot_d              = slot_q;
		bit_count_d         = bit_count_q;
		shift_byte_d        = shift_byte_q;
		latched_operation_d = latched_operation_q;
		latched_register_d  = latched_register_q;
		latched_data_d      = latched_data_q;
		received_byte_d     = received_byte_q;
		nack_flag_d         = nack_flag_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.start_request) begin
					latched_operation_d = item.operation;
					latched_register_d  = item.register_address;
					latched_data_d      = item.write_data;
					nack_flag_d         = 1'b0;
					slot_d              = SLOT_DEV_W;
					phase_d             = PH_START_A;
				end
			end
			PH_START_A: phase_d = PH_START_B;
			PH_START_B: begin
				shift_byte_d = addr_byte;
				bit_count_d  = '0;
				phase_d      = PH_BIT_LOW;
			end
			PH_BIT_LOW: phase_d = PH_BIT_HIGH;
			PH_BIT_HIGH: begin
				shift_byte_d = {shift_byte_q[ByteWidth-2:0], 1'b0};
				bit_count_d  = count_inc;
				phase_d      = (count_inc >= BitsPerByte) ? PH_ACK_LOW : PH_BIT_LOW;
			end
			PH_ACK_LOW: phase_d = PH_ACK_HIGH;
			PH_ACK_HIGH: begin
				if (item.sda_sample) begin
					nack_flag_d = 1'b1;
				end
				unique case (slot_q)
					SLOT_DEV_W: begin
						shift_byte_d = latched_register_q;
						bit_count_d  = '0;
						slot_d       = SLOT_REG;
						phase_d      = PH_BIT_LOW;
					end
					SLOT_REG: begin
						if (latched_operation_q == OpRead) begin
							slot_d  = SLOT_DEV_R;
							phase_d = PH_RESTART;
						end else begin
							shift_byte_d = latched_data_q;
							bit_count_d  = '0;
							slot_d       = SLOT_DATA;
							phase_d      = PH_BIT_LOW;
						end
					end
					SLOT_DEV_R: begin
						shift_byte_d = '0;
						bit_count_d  = '0;
						phase_d      = PH_RECV_LOW;
					end
					default: phase_d = PH_STOP_A;
				endcase
			end
			PH_RESTART:  phase_d = PH_START_A;
			PH_RECV_LOW: phase_d = PH_RECV_HIGH;
			PH_RECV_HIGH: begin
				shift_byte_d = recv_shift;
				bit_count_d  = count_inc;
				if (count_inc >= BitsPerByte) begin
					received_byte_d = recv_shift;
					phase_d         = PH_MNACK_LOW;
				end else begin
					phase_d = PH_RECV_LOW;
				end
			end
			PH_MNACK_LOW:  phase_d = PH_MNACK_HIGH;
			PH_MNACK_HIGH: phase_d = PH_STOP_A;
			PH_STOP_A:     phase_d = PH_STOP_B;
			PH_STOP_B:     phase_d = PH_STOP_C;
			default: begin
				// final stop tick and any stray code drop back to idle
				phase_d = PH_IDLE;
				slot_d  = SLOT_DEV_W;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q             <= PH_IDLE;
			slot_q              <= SLOT_DEV_W;
			bit_count_q         <= '0;
			shift_byte_q        <= '0;
			latched_operation_q <= 1'b0;
			latched_register_q  <= '0;
			latched_data_q      <= '0;
			received_byte_q     <= '0;
			nack_flag_q         <= 1'b0;
		end else if (step) begin
			phase_q             <= phase_d;
			slot_q              <= slot_d;
			bit_count_q         <= bit_count_d;
			shift_byte_q        <= shift_byte_d;
			latched_operation_q <= latched_operation_d;
			latched_register_q  <= latched_register_d;
			latched_data_q      <= latched_data_d;
			received_byte_q     <= received_byte_d;
			nack_flag_q         <= nack_flag_d;
		end
	end

	// line drive follows the phase being entered
	always_comb begin
		result.scl_level = 1'b1;
		result.sda_level = 1'b1;
		unique case (phase_d)
			PH_START_B: result.sda_level = 1'b0;
			PH_BIT_LOW: begin
				result.scl_level = 1'b0;
				result.sda_level = shift_byte_d[ByteWidth-1];
			end
			PH_BIT_HIGH: result.sda_level = shift_byte_d[ByteWidth-1];
			PH_ACK_LOW, PH_RESTART, PH_RECV_LOW, PH_MNACK_LOW: result.scl_level = 1'b0;
			PH_STOP_A: begin
				result.scl_level = 1'b0;
				result.sda_level = 1'b0;
			end
			PH_STOP_B: result.sda_level = 1'b0;
			default: ;
		endcase
		result.busy_res  = (phase_d != PH_IDLE);
		result.done_res  = (phase_d == PH_STOP_C);
		result.read_data = received_byte_d;
		result.nack_seen = nack_flag_d;
	end

endmodule

`default_nettype wire

// ===== src/i2c_register_access_master.sv =====
// I2C register access master.
//
// Channels: req carries one half-bit bus tick per transaction (start request,
// operation, register address, write data and the sampled SDA level); rsp
// returns one result per tick: SCL and SDA drive, busy, done, last read byte
// and the NACK flag. Both use valid and stall; a transaction moves at an
// edge with valid high and stall low. cfg writes the 7-bit device address
// (valid/ready, always ready); write it only while no transaction is open.
// Each accepted tick lands in the input register; the sequencer result for it is
// registered in the result register once the output side allows, and it is
// offered on rsp from there. Throughput: one tick per cycle while the receiver
// does not stall, with each sequencer step computed from the input register
// and taken into the result register. A full result register stalled by the
// receiver holds, and the input register then stalls req; nothing is lost or
// replayed.
// Reset clears the sequencer to idle, empties both registers and loads the
// device address with 104.
// Depends on i2cra_pkg and i2cra_seq.
`default_nettype none

module i2c_register_access_master
	import i2cra_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output rsp_t                      rsp,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [AddrWidth-1:0] cfg_data
);

	logic                 valid_s1;
	req_t                 item_s1;
	logic                 rsp_valid_s2;
	rsp_t                 rsp_s2;
	logic [AddrWidth-1:0] device_address_q;
	logic                 adv;
	rsp_t                 seq_result;

	assign adv       = !rsp_valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !adv;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	i2cra_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv && valid_s1),
		.item           (item_s1),
		.device_address (device_address_q),
		.result         (seq_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DeviceAddressReset;
		end else if (cfg_valid && cfg_ready) begin
			device_address_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers: load only on a move
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req;
		end
		if (adv && valid_s1) begin
			rsp_s2 <= seq_result;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_i2c_register_access_master.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for i2c_register_access_master: a directed table, then random ticks.
// Each tick is checked against a tick-level predictor of the bus sequencer kept in this file, or against the typed row.
// Depends on i2cra_pkg and the RTL of the block only.

module tb_i2c_register_access_master;
	import i2cra_pkg::*;

	localparam int unsigned QuietLimit = 2000;
	localparam int unsigned HoldAfter = 600;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned PhaseTicks = 60;

	typedef struct {
		logic                 start;
		logic                 op;
		logic [ByteWidth-1:0] regaddr;
		logic [ByteWidth-1:0] wdata;
		logic                 ack;
		logic [ByteWidth-1:0] rbyte;
		bit                   typed;
		rsp_t                 exp;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req_item = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp_item;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [AddrWidth-1:0] cfg_data = '0;

	// predicted sequencer state
	phase_t               ph = PH_IDLE;
	slot_t                sl = SLOT_DEV_W;
	logic [CountWidth-1:0] nbits = '0;
	logic [ByteWidth-1:0] shreg = '0;
	logic                 lat_op = 1'b0;
	logic [ByteWidth-1:0] lat_reg = '0;
	logic [ByteWidth-1:0] lat_dat = '0;
	logic [ByteWidth-1:0] rx_byte = '0;
	logic                 nack_f = 1'b0;
	logic [AddrWidth-1:0] dev_addr = DeviceAddressReset;

	rsp_t                 expected_ticks [$];
	rsp_t                 want;
	int unsigned          mismatches = 0;
	int unsigned          results_seen = 0;
	int unsigned          quiet_cycles = 0;
	int                   rx_wait = 0;
	bit                   rx_fast = 1'b0;
	bit                   tx_fast = 1'b0;
	logic [ByteWidth-1:0] resp_byte = '0;

	dir_row_t dir_rows [12] = '{
		// after reset: idle lines, nothing latched
		'{1'b0, OpWrite, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{1'b1, OpWrite, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
		'{1'b0, OpRead,  8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		// every acknowledge high: the flag must survive into idle
		'{1'b1, OpWrite, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, '0},
		'{1'b0, OpWrite, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
		'{1'b1, OpRead,  8'h00, 8'h00, 1'b0, 8'hA5, 0, '0},
		'{1'b0, OpRead,  8'h00, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'hA5, 1'b0}},
		'{1'b1, OpRead,  8'hFF, 8'h5A, 1'b1, 8'hFF, 0, '0},
		'{1'b0, OpWrite, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'hFF, 1'b1}},
		'{1'b1, OpRead,  8'h3C, 8'h00, 1'b0, 8'h00, 0, '0},
		// a write leaves the last read byte in place
		'{1'b1, OpWrite, 8'h81, 8'h7E, 1'b0, 8'hFF, 0, '0},
		'{1'b0, OpRead,  8'h00, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}}
	};

	i2c_register_access_master u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(inout bit fast);
		if ($urandom_range(0, 39) == 0)
			fast = !fast;
		return fast ? 0 : int'($urandom_range(0, 14));
	endfunction

	// Advance the predicted sequencer by one half-bit tick and return the lines it shows.
	function automatic rsp_t advance_bus_tick(input req_t r);
		rsp_t o;
		case (ph)
			PH_IDLE: begin
				if (r.start_request) begin
					lat_op = r.operation;
					lat_reg = r.register_address;
					lat_dat = r.write_data;
					nack_f = 1'b0;
					sl = SLOT_DEV_W;
					ph = PH_START_A;
				end
			end
			PH_START_A: ph = PH_START_B;
			PH_START_B: begin
				// address byte takes the device address current at this tick
				shreg = {dev_addr, sl == SLOT_DEV_R};
				nbits = '0;
				ph = PH_BIT_LOW;
			end
			PH_BIT_LOW: ph = PH_BIT_HIGH;
			PH_BIT_HIGH: begin
				shreg = shreg << 1;
				nbits = nbits + 1'b1;
				ph = (nbits >= BitsPerByte) ? PH_ACK_LOW : PH_BIT_LOW;
			end
			PH_ACK_LOW: ph = PH_ACK_HIGH;
			PH_ACK_HIGH: begin
				if (r.sda_sample)
					nack_f = 1'b1;
				case (sl)
					SLOT_DEV_W: begin
						sl = SLOT_REG;
						shreg = lat_reg;
						nbits = '0;
						ph = PH_BIT_LOW;
					end
					SLOT_REG: begin
						if (lat_op == OpRead) begin
							sl = SLOT_DEV_R;
							ph = PH_RESTART;
						end else begin
							sl = SLOT_DATA;
							shreg = lat_dat;
							nbits = '0;
							ph = PH_BIT_LOW;
						end
					end
					SLOT_DEV_R: begin
						shreg = '0;
						nbits = '0;
						ph = PH_RECV_LOW;
					end
					default: ph = PH_STOP_A;
				endcase
			end
			PH_RESTART: ph = PH_START_A;
			PH_RECV_LOW: ph = PH_RECV_HIGH;
			PH_RECV_HIGH: begin
				shreg = {shreg[ByteWidth-2:0], r.sda_sample};
				nbits = nbits + 1'b1;
				if (nbits >= BitsPerByte) begin
					rx_byte = shreg;
					ph = PH_MNACK_LOW;
				end else begin
					ph = PH_RECV_LOW;
				end
			end
			PH_MNACK_LOW: ph = PH_MNACK_HIGH;
			PH_MNACK_HIGH: ph = PH_STOP_A;
			PH_STOP_A: ph = PH_STOP_B;
			PH_STOP_B: ph = PH_STOP_C;
			default: begin
				sl = SLOT_DEV_W;
				ph = PH_IDLE;
			end
		endcase
		o.scl_level = 1'b1;
		o.sda_level = 1'b1;
		case (ph)
			PH_START_B: o.sda_level = 1'b0;
			PH_BIT_LOW: begin
				o.scl_level = 1'b0;
				o.sda_level = shreg[ByteWidth-1];
			end
			PH_BIT_HIGH: o.sda_level = shreg[ByteWidth-1];
			PH_ACK_LOW, PH_RESTART, PH_RECV_LOW, PH_MNACK_LOW: o.scl_level = 1'b0;
			PH_STOP_A: begin
				o.scl_level = 1'b0;
				o.sda_level = 1'b0;
			end
			PH_STOP_B: o.sda_level = 1'b0;
			default: ;
		endcase
		o.busy_res = (ph != PH_IDLE);
		o.done_res = (ph == PH_STOP_C);
		o.read_data = rx_byte;
		o.nack_seen = nack_f;
		return o;
	endfunction

	// Random tick; SDA plays the target when this tick ends an acknowledge or receive SCL-high slot.
	function automatic req_t make_tick(input logic start, input logic ack,
			input logic [ByteWidth-1:0] rd);
		req_t r;
		r.start_request = start;
		r.operation = 1'($urandom_range(0, 1));
		r.register_address = ByteWidth'($urandom_range(0, 255));
		r.write_data = ByteWidth'($urandom_range(0, 255));
		if (ph == PH_ACK_HIGH)
			r.sda_sample = ack;
		else if (ph == PH_RECV_HIGH)
			r.sda_sample = rd[ByteWidth - 1 - int'(nbits)];
		else
			r.sda_sample = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic send_tick(input req_t r, input bit use_typed, input rsp_t typed);
		rsp_t p;
		int gap;
		gap = draw_gap(tx_fast);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_item <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		p = advance_bus_tick(r);
		expected_ticks.push_back(use_typed ? typed : p);
	endtask

	task automatic wait_for_results;
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_ticks.size() != 0);
	endtask

	// Close any open bus sequence, then hold until every result is back.
	task automatic settle_bus;
		while (ph != PH_IDLE)
			send_tick(make_tick(1'b0, 1'b0, 8'h00), 1'b0, '0);
		wait_for_results();
	endtask

	task automatic write_device_address(input logic [AddrWidth-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		dev_addr = v;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		req_t r;
		logic [AddrWidth-1:0] addrs [6];
		logic ack;
		addrs[0] = 7'h7F;
		addrs[1] = 7'h00;
		addrs[2] = AddrWidth'($urandom_range(0, 127));
		addrs[3] = 7'h55;
		addrs[4] = AddrWidth'($urandom_range(0, 127));
		addrs[5] = 7'h2A;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			r = make_tick(1'b0, dir_rows[i].ack, dir_rows[i].rbyte);
			r.start_request = dir_rows[i].start;
			r.operation = dir_rows[i].op;
			r.register_address = dir_rows[i].regaddr;
			r.write_data = dir_rows[i].wdata;
			send_tick(r, dir_rows[i].typed, dir_rows[i].exp);
			// requests while busy are noise and must be ignored
			while (ph != PH_IDLE)
				send_tick(make_tick(1'($urandom_range(0, 1)), dir_rows[i].ack,
					dir_rows[i].rbyte), 1'b0, '0);
		end

		foreach (addrs[k]) begin
			settle_bus();
			write_device_address(addrs[k]);
			for (int n = 0; n < PhaseTicks; n++) begin
				ack = ($urandom_range(0, 9) == 0);
				if (ph == PH_IDLE) begin
					resp_byte = ByteWidth'($urandom_range(0, 255));
					r = make_tick($urandom_range(0, 3) != 0, ack, resp_byte);
				end else begin
					r = make_tick(1'($urandom_range(0, 1)), ack, resp_byte);
				end
				send_tick(r, 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		mismatches += expected_ticks.size();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (expected_ticks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", rsp_item);
			end else begin
				want = expected_ticks.pop_front();
				if (want.scl_level !== rsp_item.scl_level
						|| want.sda_level !== rsp_item.sda_level
						|| want.busy_res !== rsp_item.busy_res
						|| want.done_res !== rsp_item.done_res
						|| want.read_data !== rsp_item.read_data
						|| want.nack_seen !== rsp_item.nack_seen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at result %0d: expected %p, got %p",
							results_seen, want, rsp_item);
				end
			end
			results_seen++;
			// one long hold lets the block fill up and stall its input
			if (results_seen == HoldAfter)
				rx_wait = HoldCycles;
			else
				rx_wait = draw_gap(rx_fast);
		end
		if (rx_wait > 0) begin
			rsp_stall <= 1'b1;
			rx_wait--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0)
				|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
